[hw/rtl/ipid_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, register map, reset values and sequencer states for the
// incremental PID controller. No dependencies.
package ipid_pkg;

    localparam int SAMPLE_W = 16;              // setpoint / measurement
    localparam int ERR_W    = SAMPLE_W + 1;    // error, one guard bit
    localparam int WORD_W   = 32;              // Q16.16 registers and output
    localparam int FRAC_W   = 16;
    localparam int DVD_W    = 49;              // dividend: kd << 17 is the widest
    localparam int DVS_W    = 33;              // divisor: 2 * ti
    localparam int Q_W      = 51;              // signed coefficient width
    localparam int ACC_W    = 72;              // exact sum of three products
    localparam int ADDR_W   = 4;

    localparam logic [1:0] REG_GAIN_PROP     = 2'd0;
    localparam logic [1:0] REG_GAIN_DERIV    = 2'd1;
    localparam logic [1:0] REG_INTEGRAL_TIME = 2'd2;
    localparam logic [1:0] REG_SAMPLE_PERIOD = 2'd3;

    localparam logic [WORD_W-1:0] RST_GAIN_PROP     = 32'h0001_0000;
    localparam logic [WORD_W-1:0] RST_GAIN_DERIV    = 32'h0000_0000;
    localparam logic [WORD_W-1:0] RST_INTEGRAL_TIME = 32'h0001_0000;
    localparam logic [WORD_W-1:0] RST_SAMPLE_PERIOD = 32'h0001_0000;

    localparam logic [WORD_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [WORD_W-1:0] SAT_MIN = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_DT_GO,     // start Ta / (2 Ti)
        ST_DT_WAIT,
        ST_DD_GO,     // start 2 Kd / Ta
        ST_DD_WAIT,
        ST_Q0,
        ST_Q1,
        ST_IDLE,
        ST_MAC,
        ST_SAT
    } state_t;

endpackage

[hw/rtl/ipid_div.sv]
`timescale 1ns / 1ps
// Bit-serial restoring divider, one quotient bit per cycle, unsigned.
// Depends on ipid_pkg for default widths; the top level hands the widths down.
module ipid_div #(
    parameter int DVD_W = ipid_pkg::DVD_W,
    parameter int DVS_W = ipid_pkg::DVS_W
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic [DVD_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [DVS_W-1:0] rem_reg,  rem_next;
    logic [DVD_W-1:0] quo_reg,  quo_next;
    logic [DVS_W-1:0] dvs_reg,  dvs_next;
    logic [DVS_W:0]   trial;
    logic             fits;

    // dividend bits shift out of the top of quo_reg while quotient bits enter at the bottom
    assign trial = {rem_reg, quo_reg[DVD_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        quo_next = quo_reg;
        dvs_next = dvs_reg;
        if (start) begin
            cnt_next = CNT_W'(DVD_W);
            rem_next = '0;
            quo_next = dividend;
            dvs_next = divisor;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
            quo_next = {quo_reg[DVD_W-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

[hw/rtl/incremental_pid_controller_top.sv]
`timescale 1ns / 1ps
// Incremental (velocity form) PID controller, Q16.16, top level.
// Depends on ipid_pkg and ipid_div.
//
// Usage:
//  - s_ channel: one beat per sample, s_tdata = {measurement, setpoint}.
//  - m_ channel: one beat per sample, m_tdata = control_out (Q16.16, saturated).
//  - APB port: gain_prop 0x0, gain_deriv 0x4, integral_time 0x8, sample_period 0xC.
//  - The coefficients q0, q1, q2 are derived once after reset and after each
//    register write: two serial divisions (start, 49 steps, hand-off), then the
//    states ST_Q0 and ST_Q1; s_tready is low throughout.
//  - Per sample the error is multiplied into the sum one error bit per cycle,
//    three products on one 72-bit adder, then ST_SAT saturates the sum.
//    m_tvalid rises and s_tready returns in the same cycle, so a new sample is
//    taken only once the result of the last one has been loaded.
//  - A result waits in the output register while the sink stalls; the next
//    sample is still taken and computed, and holds in its final cycle until
//    the output register frees up.
//  - Reset (aresetn low, synchronous) restores register defaults, clears the
//    error and output history and starts the coefficient derivation.
module incremental_pid_controller_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    // s_tdata: [15:0] setpoint, [31:16] measurement
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [31:0]                s_tdata,
    // m_tdata: [31:0] control_out
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ipid_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int SW  = ipid_pkg::SAMPLE_W;
    localparam int EW  = ipid_pkg::ERR_W;
    localparam int WW  = ipid_pkg::WORD_W;
    localparam int QW  = ipid_pkg::Q_W;
    localparam int AW  = ipid_pkg::ACC_W;
    localparam int DDW = ipid_pkg::DVD_W;
    localparam int DSW = ipid_pkg::DVS_W;
    localparam int FW  = ipid_pkg::FRAC_W;

    // ---------------- configuration registers ----------------
    logic [WW-1:0] gain_prop_reg, gain_deriv_reg, integral_time_reg, sample_period_reg;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_prop_reg     <= ipid_pkg::RST_GAIN_PROP;
            gain_deriv_reg    <= ipid_pkg::RST_GAIN_DERIV;
            integral_time_reg <= ipid_pkg::RST_INTEGRAL_TIME;
            sample_period_reg <= ipid_pkg::RST_SAMPLE_PERIOD;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                ipid_pkg::REG_GAIN_PROP:     gain_prop_reg     <= pwdata;
                ipid_pkg::REG_GAIN_DERIV:    gain_deriv_reg    <= pwdata;
                ipid_pkg::REG_INTEGRAL_TIME: integral_time_reg <= pwdata;
                ipid_pkg::REG_SAMPLE_PERIOD: sample_period_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            ipid_pkg::REG_GAIN_PROP:     prdata = gain_prop_reg;
            ipid_pkg::REG_GAIN_DERIV:    prdata = gain_deriv_reg;
            ipid_pkg::REG_INTEGRAL_TIME: prdata = integral_time_reg;
            ipid_pkg::REG_SAMPLE_PERIOD: prdata = sample_period_reg;
            default:                     prdata = '0;
        endcase
    end

    // ---------------- shared divider ----------------
    logic           div_start, div_busy;
    logic [DDW-1:0] div_dividend, div_quotient;
    logic [DSW-1:0] div_divisor;
    logic [WW-1:0]  ti_safe, ta_safe;

    // a zero time register counts as one LSB
    assign ti_safe = (integral_time_reg == '0) ? WW'(1) : integral_time_reg;
    assign ta_safe = (sample_period_reg == '0) ? WW'(1) : sample_period_reg;

    ipid_pkg::state_t state_reg, state_next;

    always_comb begin
        if (state_reg == ipid_pkg::ST_DT_GO) begin
            div_dividend = DDW'({sample_period_reg, {FW{1'b0}}});
            div_divisor  = {ti_safe, 1'b0};
        end else begin
            div_dividend = DDW'({gain_deriv_reg, {(FW + 1){1'b0}}});
            div_divisor  = DSW'(ta_safe);
        end
    end

    assign div_start = (state_reg == ipid_pkg::ST_DT_GO) || (state_reg == ipid_pkg::ST_DD_GO);

    ipid_div #(
        .DVD_W (DDW),
        .DVS_W (DSW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    // ---------------- datapath registers ----------------
    logic [DDW-1:0]       th_reg, th_next;        // Ta / (2 Ti)
    logic [DDW-1:0]       d2_reg, d2_next;        // 2 Kd / Ta; Kd / Ta is d2 >> 1
    logic signed [QW-1:0] q0_reg, q0_next;
    logic signed [QW-1:0] q1_reg, q1_next;
    logic [AW-1:0]        acc_reg, acc_next;
    logic [AW-1:0]        qsh_reg, qsh_next;
    logic [EW-1:0]        esh_reg, esh_next;
    logic [EW-1:0]        e0_reg, e0_next;
    logic [EW-1:0]        err_last_reg, err_last_next;
    logic [EW-1:0]        err_before_reg, err_before_next;
    logic [WW-1:0]        out_last_reg, out_last_next;
    logic [4:0]           bit_reg, bit_next;
    logic [1:0]           term_reg, term_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [WW-1:0]        m_tdata_reg, m_tdata_next;

    logic                 s_accept, out_free, load_out;
    logic [EW-1:0]        e_in;
    logic [QW-1:0]        d1_ext, kp_ext, th_ext, d2_ext;
    logic                 last_bit, sub_bit;
    logic [AW-1:0]        addend;
    logic                 acc_fits;
    logic [WW-1:0]        sat_val;

    assign s_tready = (state_reg == ipid_pkg::ST_IDLE);
    assign s_accept = s_tvalid & s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign load_out = (state_reg == ipid_pkg::ST_SAT) && out_free;

    assign e_in = EW'($signed({s_tdata[2*SW-1], s_tdata[2*SW-1:SW]}) -
                      $signed({s_tdata[SW-1], s_tdata[SW-1:0]}));

    assign d1_ext = QW'(d2_reg >> 1);
    assign kp_ext = QW'(gain_prop_reg);
    assign th_ext = QW'(th_reg);
    assign d2_ext = QW'(d2_reg);

    // the error's top bit carries negative weight
    assign last_bit = (bit_reg == 5'(EW - 1));
    assign sub_bit  = last_bit & esh_reg[0];
    assign addend   = esh_reg[0] ? qsh_reg : '0;

    assign acc_fits = (&acc_reg[AW-1:WW-1]) || !(|acc_reg[AW-1:WW-1]);
    assign sat_val  = acc_fits ? acc_reg[WW-1:0]
                    : (acc_reg[AW-1] ? ipid_pkg::SAT_MIN : ipid_pkg::SAT_MAX);

    always_comb begin
        state_next      = state_reg;
        th_next         = th_reg;
        d2_next         = d2_reg;
        q0_next         = q0_reg;
        q1_next         = q1_reg;
        acc_next        = acc_reg;
        qsh_next        = qsh_reg;
        esh_next        = esh_reg;
        e0_next         = e0_reg;
        err_last_next   = err_last_reg;
        err_before_next = err_before_reg;
        out_last_next   = out_last_reg;
        bit_next        = bit_reg;
        term_next       = term_reg;
        m_tdata_next    = m_tdata_reg;
        m_tvalid_next   = m_tvalid_reg & !m_tready;

        unique case (state_reg)
            ipid_pkg::ST_DT_GO: state_next = ipid_pkg::ST_DT_WAIT;
            ipid_pkg::ST_DT_WAIT: begin
                if (!div_busy) begin
                    th_next    = div_quotient;
                    state_next = ipid_pkg::ST_DD_GO;
                end
            end
            ipid_pkg::ST_DD_GO: state_next = ipid_pkg::ST_DD_WAIT;
            ipid_pkg::ST_DD_WAIT: begin
                if (!div_busy) begin
                    d2_next    = div_quotient;
                    state_next = ipid_pkg::ST_Q0;
                end
            end
            ipid_pkg::ST_Q0: begin
                q0_next    = $signed(kp_ext + th_ext + d1_ext);
                state_next = ipid_pkg::ST_Q1;
            end
            ipid_pkg::ST_Q1: begin
                q1_next    = $signed(th_ext - kp_ext - d2_ext);
                state_next = ipid_pkg::ST_IDLE;
            end
            ipid_pkg::ST_IDLE: begin
                if (s_accept) begin
                    e0_next    = e_in;
                    esh_next   = e_in;
                    qsh_next   = AW'(q0_reg);
                    acc_next   = AW'($signed(out_last_reg));
                    bit_next   = '0;
                    term_next  = 2'd0;
                    state_next = ipid_pkg::ST_MAC;
                end
            end
            ipid_pkg::ST_MAC: begin
                acc_next = acc_reg + (addend ^ {AW{sub_bit}}) + AW'(sub_bit);
                qsh_next = {qsh_reg[AW-2:0], 1'b0};
                esh_next = esh_reg >> 1;
                bit_next = bit_reg + 1'b1;
                if (last_bit) begin
                    bit_next  = '0;
                    term_next = term_reg + 1'b1;
                    case (term_reg)
                        2'd0: begin
                            qsh_next = AW'(q1_reg);
                            esh_next = err_last_reg;
                        end
                        2'd1: begin
                            qsh_next = AW'(d1_ext);
                            esh_next = err_before_reg;
                        end
                        default: state_next = ipid_pkg::ST_SAT;
                    endcase
                end
            end
            ipid_pkg::ST_SAT: begin
                if (out_free) begin
                    m_tdata_next    = sat_val;
                    m_tvalid_next   = 1'b1;
                    out_last_next   = sat_val;
                    err_before_next = err_last_reg;
                    err_last_next   = e0_reg;
                    state_next      = ipid_pkg::ST_IDLE;
                end
            end
            default: state_next = ipid_pkg::ST_DT_GO;
        endcase

        // new register contents: derive the coefficients again
        if (cfg_wr) begin
            state_next = ipid_pkg::ST_DT_GO;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ipid_pkg::ST_DT_GO;
            m_tvalid_reg   <= 1'b0;
            err_last_reg   <= '0;
            err_before_reg <= '0;
            out_last_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            m_tvalid_reg   <= m_tvalid_next;
            err_last_reg   <= err_last_next;
            err_before_reg <= err_before_next;
            out_last_reg   <= out_last_next;
        end
        th_reg      <= th_next;
        d2_reg      <= d2_next;
        q0_reg      <= q0_next;
        q1_reg      <= q1_next;
        acc_reg     <= acc_next;
        qsh_reg     <= qsh_next;
        esh_reg     <= esh_next;
        e0_reg      <= e0_next;
        bit_reg     <= bit_next;
        term_reg    <= term_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`ifndef ASSERT_OFF
    // a result never overwrites a beat the sink has not taken
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> !(m_tvalid_reg && !m_tready))
        else $error("output register overwritten while stalled");

    a_load_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |=> m_tvalid && (m_tdata == $past(sat_val)))
        else $error("saturated result not presented");

    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !cfg_wr) |=> (state_reg == ipid_pkg::ST_MAC) && !s_tready)
        else $error("accepted sample did not start the multiply pass");

    a_cfg_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr |=> !s_tready && (state_reg == ipid_pkg::ST_DT_GO))
        else $error("register write did not restart coefficient derivation");
`endif

endmodule
